FILE: hw/rtl/sch_pkg.sv
// shared types, constants and helpers for the segment cylinder hit test
package sch_pkg;

  // default number of search rounds
  localparam int unsigned SearchRoundsDef = 10;
  // pipeline depth of the distance unit
  localparam int unsigned DistLat = 4;
  // search bound for t = 1.0 in Q1.16
  localparam logic [16:0] OneQ16 = 17'h10000;
  // ceil(2^18 / 3), exact floor division by three for values up to 2^16
  localparam logic [17:0] ThirdRecip = 18'd87382;

  // configuration register indexes
  localparam logic RegBoxHeight = 1'b0;
  localparam logic RegBoxRadius = 1'b1;

  // geometry of one request
  typedef struct packed {
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } geom_t;

  // search state handed from cell to cell
  typedef struct packed {
    logic [16:0] lo;
    logic [16:0] hi;
    geom_t       g;
  } item_t;

  // side data held while the distance unit works
  typedef struct packed {
    item_t       it;
    logic [16:0] x;
    logic [16:0] y;
  } side_t;

  // magnitude of a 35-bit signed value
  function automatic logic [33:0] mag35(logic signed [34:0] v);
    logic [34:0] n;
    n = 35'(-v);
    return v[34] ? n[33:0] : v[33:0];
  endfunction

endpackage

FILE: hw/rtl/sch_dist.sv
// pipelined squared distance from a segment point to the cylinder
module sch_dist
  import sch_pkg::*;
(
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [16:0]  t_i,
  input  geom_t        g_i,
  input  logic [30:0]  height_i,
  output logic [69:0]  dist_o
);

  // stage 1: products of the segment deltas with t
  logic signed [32:0] dx_d, dy_d, dz_d;
  logic signed [17:0] tt;
  logic signed [50:0] px_q, py_q, pz_q;
  logic signed [31:0] sx_q, sy_q, sz_q, bx_q, by_q, bz_q;
  logic signed [34:0] top_q;

  always_comb begin
    tt   = $signed({1'b0, t_i});
    dx_d = 33'(g_i.end_x) - 33'(g_i.start_x);
    dy_d = 33'(g_i.end_y) - 33'(g_i.start_y);
    dz_d = 33'(g_i.end_z) - 33'(g_i.start_z);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= dx_d * tt;
      py_q  <= dy_d * tt;
      pz_q  <= dz_d * tt;
      sx_q  <= g_i.start_x;
      sy_q  <= g_i.start_y;
      sz_q  <= g_i.start_z;
      bx_q  <= g_i.base_x;
      by_q  <= g_i.base_y;
      bz_q  <= g_i.base_z;
      top_q <= 35'(g_i.base_y) + $signed({4'b0, height_i});
    end
  end

  // stage 2: point on the segment, offsets and their magnitudes
  logic signed [34:0] ptx, pty, ptz, ox, oz, oyb, oyt;
  logic               band_d;
  logic [33:0]        mx_q, mz_q, myb_q, myt_q;
  logic               band_q;

  always_comb begin
    ptx    = 35'(sx_q) + $signed(px_q[50:16]);
    pty    = 35'(sy_q) + $signed(py_q[50:16]);
    ptz    = 35'(sz_q) + $signed(pz_q[50:16]);
    ox     = ptx - 35'(bx_q);
    oz     = ptz - 35'(bz_q);
    oyb    = pty - 35'(by_q);
    oyt    = pty - top_q;
    band_d = !((pty > top_q) || (pty < 35'(by_q)));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q   <= mag35(ox);
      mz_q   <= mag35(oz);
      myb_q  <= mag35(oyb);
      myt_q  <= mag35(oyt);
      band_q <= band_d;
    end
  end

  // stage 3: squares
  logic [67:0] sx2_q, sz2_q, syb2_q, syt2_q;
  logic        band2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx2_q   <= mx_q * mx_q;
      sz2_q   <= mz_q * mz_q;
      syb2_q  <= myb_q * myb_q;
      syt2_q  <= myt_q * myt_q;
      band2_q <= band_q;
    end
  end

  // stage 4: sums and nearer end of the axis
  logic [69:0] h_d, db_d, dt_d, res_d;
  logic [69:0] res_q;

  always_comb begin
    h_d  = 70'(sx2_q) + 70'(sz2_q);
    db_d = h_d + 70'(syb2_q);
    dt_d = h_d + 70'(syt2_q);
    if (band2_q) begin
      res_d = h_d;
    end else if (dt_d < db_d) begin
      res_d = dt_d;
    end else begin
      res_d = db_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign dist_o = res_q;

endmodule

FILE: hw/rtl/sch_round.sv
// one search round cell: splits the interval and keeps the nearer side
module sch_round
  import sch_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  item_t        data_i,
  input  logic [30:0]  height_i,
  output logic         valid_o,
  output item_t        data_o
);

  // split points of the interval
  logic [16:0] range_d, third_d;
  logic [34:0] prod_d;
  logic        r0_valid_q;
  item_t       r0_q;
  logic [16:0] x_q, y_q;

  always_comb begin
    range_d = data_i.hi - data_i.lo;
    prod_d  = 35'(range_d) * 35'(ThirdRecip);
    third_d = prod_d[34:18];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_valid_q <= 1'b0;
    end else if (en_i) begin
      r0_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q <= data_i;
      x_q  <= data_i.lo + third_d;
      y_q  <= data_i.hi - third_d;
    end
  end

  // distances at both split points
  logic [69:0] dist_x, dist_y;

  sch_dist u_dist_x (
    .clk_i    (clk_i),
    .en_i     (en_i),
    .t_i      (x_q),
    .g_i      (r0_q.g),
    .height_i (height_i),
    .dist_o   (dist_x)
  );

  sch_dist u_dist_y (
    .clk_i    (clk_i),
    .en_i     (en_i),
    .t_i      (y_q),
    .g_i      (r0_q.g),
    .height_i (height_i),
    .dist_o   (dist_y)
  );

  // side data delayed alongside the distance units
  side_t pipe_q  [DistLat];
  logic  pvld_q  [DistLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DistLat; i++) begin
        pvld_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      pvld_q[0] <= r0_valid_q;
      for (int i = 1; i < DistLat; i++) begin
        pvld_q[i] <= pvld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= '{it: r0_q, x: x_q, y: y_q};
      for (int i = 1; i < DistLat; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  // keep the side with the smaller distance, ties move lo up
  item_t out_d;
  logic  out_valid_q;
  item_t out_q;

  always_comb begin
    out_d = pipe_q[DistLat-1].it;
    if (dist_x < dist_y) begin
      out_d.hi = pipe_q[DistLat-1].y;
    end else begin
      out_d.lo = pipe_q[DistLat-1].x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= pvld_q[DistLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

FILE: hw/rtl/segment_cylinder_hit_test.sv
// segment against vertical cylinder hit test, chain of ternary search cells
// each round cell registers the split, runs four distance stages and registers the decision;
// then a final distance unit and the compare register produce the result
// throughput: one request per cycle; the whole chain holds while the result waits
// reset: rst_ni clears all valid flags and sets box_height to 2.0 and box_radius to 0.5
module segment_cylinder_hit_test
  import sch_pkg::*;
#(
  parameter int unsigned SEARCH_ROUNDS = SearchRoundsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // base_x, base_y, base_z, start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [287:0] s_axis_tdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // hit, near_fraction[15:0], zero padding
  output logic [23:0]  m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [30:0]  cfg_data_i
);

  // configuration registers
  logic [30:0] height_q, radius_q;
  logic [61:0] r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= 31'd131072;
      radius_q <= 31'd32768;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBoxHeight: height_q <= cfg_data_i;
        RegBoxRadius: radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= 62'(radius_q) * 62'(radius_q);
  end

  // whole chain advances unless the result is stalled
  logic out_valid_q;
  logic en;
  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // unpack the request
  item_t first;
  always_comb begin
    first.lo        = '0;
    first.hi        = OneQ16;
    first.g.base_x  = s_axis_tdata_i[31:0];
    first.g.base_y  = s_axis_tdata_i[63:32];
    first.g.base_z  = s_axis_tdata_i[95:64];
    first.g.start_x = s_axis_tdata_i[127:96];
    first.g.start_y = s_axis_tdata_i[159:128];
    first.g.start_z = s_axis_tdata_i[191:160];
    first.g.end_x   = s_axis_tdata_i[223:192];
    first.g.end_y   = s_axis_tdata_i[255:224];
    first.g.end_z   = s_axis_tdata_i[287:256];
  end

  // chain of search round cells
  logic  cvld  [SEARCH_ROUNDS+1];
  item_t cdata [SEARCH_ROUNDS+1];

  assign cvld[0]  = s_axis_tvalid_i;
  assign cdata[0] = first;

  for (genvar r = 0; r < SEARCH_ROUNDS; r++) begin : g_round
    sch_round u_round (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (cvld[r]),
      .data_i   (cdata[r]),
      .height_i (height_q),
      .valid_o  (cvld[r+1]),
      .data_o   (cdata[r+1])
    );
  end

  // distance at the final lower bound
  logic [69:0] dist_f;

  sch_dist u_dist_final (
    .clk_i    (clk_i),
    .en_i     (en),
    .t_i      (cdata[SEARCH_ROUNDS].lo),
    .g_i      (cdata[SEARCH_ROUNDS].g),
    .height_i (height_q),
    .dist_o   (dist_f)
  );

  logic [15:0] flo_q  [DistLat];
  logic        fvld_q [DistLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DistLat; i++) begin
        fvld_q[i] <= 1'b0;
      end
    end else if (en) begin
      fvld_q[0] <= cvld[SEARCH_ROUNDS];
      for (int i = 1; i < DistLat; i++) begin
        fvld_q[i] <= fvld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flo_q[0] <= cdata[SEARCH_ROUNDS].lo[15:0];
      for (int i = 1; i < DistLat; i++) begin
        flo_q[i] <= flo_q[i-1];
      end
    end
  end

  // result register
  logic        hit_q;
  logic [15:0] frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fvld_q[DistLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= !(70'(r2_q) < dist_f);
      frac_q <= flo_q[DistLat-1];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, frac_q, hit_q};

endmodule

FILE: bench/tb.sv
// testbench for the segment cylinder hit test: random and directed requests checked against a predictor
module tb
  import sch_pkg::*;
();

  localparam int unsigned Rounds = 10;
  localparam int unsigned Lat = 6 * Rounds + 5;

  typedef struct {
    logic       hit;
    logic [15:0] frac;
  } hit_res_t;

  logic         clk_i;
  logic         rst_ni;
  logic [287:0] s_axis_tdata_i;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [23:0]  m_axis_tdata_o;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [30:0]  cfg_data_i;

  segment_cylinder_hit_test #(.SEARCH_ROUNDS(Rounds)) DUT (.*);

  // predictor copy of the registers
  logic [30:0] height_q, radius_q;

  geom_t    req_q[$];
  hit_res_t hits_q[$];
  int       mismatches, n_results, n_hits, cycles;
  logic     driving;
  int       gap_left, burst_left, stall_cnt;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // point on the segment at fraction t, floor rounding
  function automatic logic signed [34:0] lerp_pt(logic signed [31:0] s, logic signed [31:0] e,
                                                logic [16:0] t);
    logic signed [51:0] p;
    p = (52'(e) - 52'(s)) * $signed({35'd0, t});
    return 35'(s) + 35'(p >>> 16);
  endfunction

  function automatic logic [69:0] dist_sq(geom_t g, logic [16:0] t);
    logic signed [35:0] dx, dz, dy_b, dy_t, py, top;
    logic [69:0] h, db, dt;
    dx = 36'(lerp_pt(g.start_x, g.end_x, t)) - 36'(g.base_x);
    dz = 36'(lerp_pt(g.start_z, g.end_z, t)) - 36'(g.base_z);
    py = 36'(lerp_pt(g.start_y, g.end_y, t));
    top = 36'(g.base_y) + $signed({5'd0, height_q});
    h = 70'(dx) * 70'(dx) + 70'(dz) * 70'(dz);
    if (py > top || py < 36'(g.base_y)) begin
      dy_b = py - 36'(g.base_y);
      dy_t = py - top;
      db = h + 70'(dy_b) * 70'(dy_b);
      dt = h + 70'(dy_t) * 70'(dy_t);
      return (dt < db) ? dt : db;
    end
    return h;
  endfunction

  function automatic hit_res_t predict_hit(geom_t g);
    logic [16:0] lo, hi, third, x, y;
    hit_res_t r;
    lo = '0;
    hi = OneQ16;
    for (int i = 0; i < Rounds; i++) begin
      third = 17'((hi - lo) / 17'd3);
      x = lo + third;
      y = hi - third;
      if (dist_sq(g, x) < dist_sq(g, y)) hi = y;
      else lo = x;
    end
    r.hit = (dist_sq(g, lo) <= 70'(radius_q) * 70'(radius_q));
    r.frac = lo[15:0];
    return r;
  endfunction

  // sender: bursts with gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (driving && req_q.size() > 0 && gap_left == 0) begin
        s_axis_tdata_i <= {req_q[0].end_z, req_q[0].end_y, req_q[0].end_x, req_q[0].start_z,
                           req_q[0].start_y, req_q[0].start_x, req_q[0].base_z,
                           req_q[0].base_y, req_q[0].base_x};
        hits_q.push_back(predict_hit(req_q[0]));
        req_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(20, 1);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // receiver: stall pattern and check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        m_axis_tready_i <= 1'b0;
      end else if ($urandom_range(9) == 0) begin
        stall_cnt <= $urandom_range(8, 1);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_results++;
        if (m_axis_tdata_o[0]) n_hits++;
        if (hits_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata_o);
        end else begin
          if (m_axis_tdata_o[0] !== hits_q[0].hit || m_axis_tdata_o[16:1] !== hits_q[0].frac) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: hit exp %b got %b, fraction exp %h got %h", hits_q[0].hit,
                       m_axis_tdata_o[0], hits_q[0].frac, m_axis_tdata_o[16:1]);
          end
          hits_q.pop_front();
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == RegBoxHeight) height_q = val;
    else radius_q = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    driving = 1'b1;
    while (req_q.size() > 0 || hits_q.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
    driving = 1'b0;
    repeat (Lat + 5) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord(logic [31:0] center, int spread);
    case ($urandom_range(5))
      0: return $urandom;
      1: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
      default: return center + $signed($urandom_range(2 * spread) - spread);
    endcase
  endfunction

  task automatic add_req(logic [31:0] v[9]);
    geom_t g;
    g = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    req_q.push_back(g);
  endtask

  // random near-miss and crossing segments around a random base
  task automatic random_reqs(int n);
    logic [31:0] v[9];
    logic [31:0] c;
    int spread;
    for (int k = 0; k < n; k++) begin
      c = $urandom;
      spread = ($urandom_range(1)) ? 32'h40000 : 32'h4000000;
      for (int j = 0; j < 3; j++) v[j] = ($urandom_range(7) == 0) ? $urandom : c + j;
      for (int j = 3; j < 9; j++) v[j] = rnd_coord(v[j % 3], spread);
      if ($urandom_range(15) == 0) for (int j = 6; j < 9; j++) v[j] = v[j - 3];
      add_req(v);
    end
  endtask

  initial begin
    logic [31:0] v[9];
    cfg_we_i = 1'b0;
    cfg_idx_i = RegBoxHeight;
    cfg_data_i = '0;
    height_q = 31'd131072;
    radius_q = 31'd32768;
    driving = 1'b0;
    mismatches = 0;
    n_results = 0;
    n_hits = 0;
    cycles = 0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: crossing, degenerate, extremes, height band edges
    v = '{0, 0, 0, -32'sh20000, 32'h10000, 0, 32'h20000, 32'h10000, 0};
    add_req(v);
    v = '{0, 0, 0, 32'h4000, 32'h8000, 0, 32'h4000, 32'h8000, 0};
    add_req(v);
    v = '{0, 0, 0, 32'h40000, 32'h40000, 32'h40000, 32'h40000, 32'h40000, 32'h40000};
    add_req(v);
    v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
          32'h80000000, 32'h80000000, 32'h80000000};
    add_req(v);
    v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
          32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    add_req(v);
    v = '{0, 0, 0, -32'sh10000, 32'h20000, 0, 32'h10000, 32'h20000, 0};
    add_req(v);
    v = '{0, 0, 0, -32'sh10000, 0, 0, 32'h10000, 0, 0};
    add_req(v);
    v = '{0, 0, 0, 0, 32'h30000, 0, 0, 32'h30000, 32'h10000};
    add_req(v);
    v = '{0, 0, 0, 0, -32'sh8000, 32'h8000, 0, -32'sh8000, 32'h8000};
    add_req(v);
    v = '{0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
          32'h7fffffff};
    add_req(v);
    v = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
          32'hffffffff, 32'hffffffff, 32'hffffffff};
    add_req(v);
    random_reqs(150);
    drain();

    // register extremes and random settings
    write_reg(RegBoxHeight, 31'd0);
    write_reg(RegBoxRadius, 31'd0);
    random_reqs(100);
    drain();
    write_reg(RegBoxHeight, 31'h7fffffff);
    write_reg(RegBoxRadius, 31'h7fffffff);
    random_reqs(100);
    drain();
    write_reg(RegBoxHeight, 31'($urandom_range(32'h100000)));
    write_reg(RegBoxRadius, 31'($urandom_range(32'h400000)));
    random_reqs(150);
    drain();
    write_reg(RegBoxHeight, 31'($urandom));
    write_reg(RegBoxRadius, 31'($urandom));
    random_reqs(150);
    drain();

    $display("covered %0d requests over five register settings, %0d hits", n_results, n_hits);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sch_pkg.sv
hw/rtl/sch_dist.sv
hw/rtl/sch_round.sv
hw/rtl/segment_cylinder_hit_test.sv
bench/tb.sv
